// ----- design/sha256md_pkg.sv -----
`default_nettype none
package sha256md_pkg;

	// One input word: a message byte, its presence flag and the end-of-message mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_word_t;

	// One output word of the digest.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_word_t;

	// Eight 32-bit variables, index 0 is a (or H0).
	typedef logic [7:0][31:0] wv_t;

	localparam wv_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ----- design/sha256md_round.sv -----
`default_nettype none
// One SHA-256 compression round over the eight working variables.
module sha256md_round
	import sha256md_pkg::*;
(
	input  wire wv_t         wv,
	input  wire logic [31:0] w,
	input  wire logic [31:0] k,
	output wv_t              wv_next
);

	logic [31:0] a, b, c, d, e, f, g, h;
	logic [31:0] sig1, ch, t1, sig0, maj, t2;

	always_comb begin
		a = wv[0];
		b = wv[1];
		c = wv[2];
		d = wv[3];
		e = wv[4];
		f = wv[5];
		g = wv[6];
		h = wv[7];
		sig1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
		ch   = (e & f) ^ (~e & g);
		t1   = h + sig1 + ch + k + w;
		sig0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
		maj  = (a & b) ^ (a & c) ^ (b & c);
		t2   = sig0 + maj;
		wv_next[0] = t1 + t2;
		wv_next[1] = a;
		wv_next[2] = b;
		wv_next[3] = c;
		wv_next[4] = d + t1;
		wv_next[5] = e;
		wv_next[6] = f;
		wv_next[7] = g;
	end

endmodule
`default_nettype wire

// ----- design/sha256_message_digest_top.sv -----
`default_nettype none
// SHA-256 digest engine over a byte stream. Each word on the msg channel carries at most
// one message byte and may mark the end of the message; a word with neither has no
// effect. A word that holds a byte and does not complete a 64-byte block is stored at
// its byte position. A word that completes a block holds the input off for 64
// compression rounds, one per cycle through a single shared round unit, and a fold
// step that adds the result into the hash. On the end-of-message word the block pads the
// message (0x80, zeros, 64-bit big-endian bit length), which costs one padding step plus
// one compression, or two padding steps and two compressions when fewer than nine bytes
// are free in the last block. It then presents the eight digest words on the dig channel,
// most significant first, one per accepted word, and reinitializes for the next message.
// The input stays stalled from the end-of-message word until the eighth digest word has
// been taken. The bit length wraps modulo 2^64.
module sha256_message_digest_top
	import sha256md_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      msg_valid,
	output logic           msg_stall,
	input  wire msg_word_t msg,
	output logic           dig_valid,
	input  wire logic      dig_stall,
	output dig_word_t      dig
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_PAD2  = 3'd2;
	localparam logic [2:0] S_ROUND = 3'd3;
	localparam logic [2:0] S_FOLD  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	// Where the sequencer goes after a compression has been folded in.
	localparam logic [1:0] NX_IDLE = 2'd0;
	localparam logic [1:0] NX_PAD  = 2'd1;
	localparam logic [1:0] NX_PAD2 = 2'd2;
	localparam logic [1:0] NX_OUT  = 2'd3;

	logic [2:0]  state_q;
	logic [1:0]  next_q;
	logic [5:0]  round_q;
	logic [2:0]  oidx_q;
	logic [63:0] bitlen_q;
	wv_t         hash_q;
	wv_t         wv_q;
	wv_t         wv_next;

	// The block buffer and the rolling message schedule share one 16-word shift line.
	// Bytes land in it by position; during compression it shifts by one word a round,
	// so the schedule taps W[t-16], W[t-15], W[t-7] and W[t-2] sit at fixed places.
	logic [31:0] win_q [16];
	logic [31:0] win_d [16];

	logic        msg_acc;
	logic        dig_acc;
	logic [5:0]  pos;
	logic [31:0] sched_w;
	logic [31:0] round_w;
	logic [31:0] s0, s1;
	logic [5:0]  bidx;

	assign msg_stall = (state_q != S_IDLE);
	assign msg_acc   = msg_valid && !msg_stall;
	assign dig_valid = (state_q == S_OUT);
	assign dig_acc   = dig_valid && !dig_stall;
	assign pos       = bitlen_q[8:3];

	assign dig.digest_word = hash_q[oidx_q];
	assign dig.word_index  = oidx_q;
	assign dig.last_word   = (oidx_q == 3'd7);

	always_comb begin
		s0 = ror32(win_q[1], 7) ^ ror32(win_q[1], 18) ^ (win_q[1] >> 3);
		s1 = ror32(win_q[14], 17) ^ ror32(win_q[14], 19) ^ (win_q[14] >> 10);
		sched_w = win_q[0] + s0 + win_q[9] + s1;
		round_w = (round_q < 6'd16) ? win_q[0] : sched_w;
	end

	sha256md_round u_round (
		.wv      (wv_q),
		.w       (round_w),
		.k       (ROUND_K[round_q]),
		.wv_next (wv_next)
	);

	always_comb begin
		bidx = '0;
		win_d = win_q;
		case (state_q)
			S_IDLE: begin
				if (msg_acc && msg.has_byte) begin
					win_d[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = msg.data_byte;
				end
			end
			S_PAD: begin
				// The pad byte goes at the fill position and everything after it clears.
				for (int i = 0; i < 16; i++) begin
					for (int j = 0; j < 4; j++) begin
						bidx = 6'(i * 4 + j);
						if (bidx == pos) begin
							win_d[i][8 * (3 - j) +: 8] = PAD_BYTE;
						end else if (bidx > pos) begin
							win_d[i][8 * (3 - j) +: 8] = 8'h00;
						end
					end
				end
				// The length fits in this block only when the pad byte lands before byte 56.
				if (pos < 6'd56) begin
					win_d[14] = bitlen_q[63:32];
					win_d[15] = bitlen_q[31:0];
				end
			end
			S_PAD2: begin
				for (int i = 0; i < 14; i++) begin
					win_d[i] = '0;
				end
				win_d[14] = bitlen_q[63:32];
				win_d[15] = bitlen_q[31:0];
			end
			S_ROUND: begin
				for (int i = 0; i < 15; i++) begin
					win_d[i] = win_q[i + 1];
				end
				win_d[15] = round_w;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			next_q   <= NX_IDLE;
			round_q  <= '0;
			oidx_q   <= '0;
			bitlen_q <= '0;
			hash_q   <= INIT_HASH;
			wv_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						if (msg.has_byte) begin
							bitlen_q <= bitlen_q + 64'd8;
						end
						if (msg.has_byte && pos == 6'd63) begin
							// This byte fills the block: compress it before any padding.
							wv_q    <= hash_q;
							round_q <= '0;
							next_q  <= msg.end_of_message ? NX_PAD : NX_IDLE;
							state_q <= S_ROUND;
						end else if (msg.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					wv_q    <= hash_q;
					round_q <= '0;
					next_q  <= (pos < 6'd56) ? NX_OUT : NX_PAD2;
					state_q <= S_ROUND;
				end
				S_PAD2: begin
					wv_q    <= hash_q;
					round_q <= '0;
					next_q  <= NX_OUT;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					wv_q    <= wv_next;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + wv_q[i];
					end
					case (next_q)
						NX_IDLE: state_q <= S_IDLE;
						NX_PAD:  state_q <= S_PAD;
						NX_PAD2: state_q <= S_PAD2;
						NX_OUT: begin
							oidx_q  <= '0;
							state_q <= S_OUT;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_OUT: begin
					if (dig_acc) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							hash_q   <= INIT_HASH;
							bitlen_q <= '0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
